// ===== sv/srpm_pkg.sv =====
// shared types and constants for the stereo route peak meter
package srpm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    // decay by 0.95 as a q15 multiply
    localparam int unsigned  DECAY_W     = 15;
    localparam logic [14:0]  DECAY_MUL   = 15'd31130;
    localparam int unsigned  DECAY_SHIFT = 15;
    localparam int unsigned  PROD_W      = LEVEL_W + DECAY_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEREO     = 3'd0,
        MODE_MUTE_LEFT  = 3'd1,
        MODE_MUTE_RIGHT = 3'd2,
        MODE_COPY_L2R   = 3'd3,
        MODE_COPY_R2L   = 3'd4
    } t_chan_mode;

    localparam logic [COUNT_W-1:0] COUNT_NONE   = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_MONO   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_STEREO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL_SCALE = 16'h8000;

    // per-lane control for one accepted frame
    typedef struct packed {
        logic track;   // fold this sample into the running peak
        logic update;  // refresh the displayed level
        logic clear;   // restart the running peak after this frame
    } t_lane_ctl;

endpackage

// ===== sv/srpm_if.sv =====
// handshake interfaces for frame input, frame output and register writes
interface srpm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [srpm_pkg::SAMPLE_W-1:0]  left_in;
    logic signed [srpm_pkg::SAMPLE_W-1:0]  right_in;
    logic                                  block_end;
    logic                                  block_empty;

    modport source (output valid, left_in, right_in, block_end, block_empty, input ready);
    modport sink   (input valid, left_in, right_in, block_end, block_empty, output ready);
endinterface

interface srpm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [srpm_pkg::SAMPLE_W-1:0]  left_out;
    logic signed [srpm_pkg::SAMPLE_W-1:0]  right_out;
    logic                                  levels_updated;
    logic        [srpm_pkg::LEVEL_W-1:0]   left_level;
    logic        [srpm_pkg::LEVEL_W-1:0]   right_level;

    modport source (output valid, left_out, right_out, levels_updated, left_level,
                    right_level, input ready);
    modport sink   (input valid, left_out, right_out, levels_updated, left_level,
                    right_level, output ready);
endinterface

interface srpm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [srpm_pkg::CFG_IDX_W-1:0]        index;
    logic [srpm_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/srpm_route.sv =====
// channel routing of one frame by mode and channel count
module srpm_route (
    input  logic [srpm_pkg::MODE_W-1:0]         i_mode,
    input  logic [srpm_pkg::COUNT_W-1:0]        i_count,
    input  logic                                i_empty,
    input  logic signed [srpm_pkg::SAMPLE_W-1:0] i_left,
    input  logic signed [srpm_pkg::SAMPLE_W-1:0] i_right,
    output logic signed [srpm_pkg::SAMPLE_W-1:0] o_left,
    output logic signed [srpm_pkg::SAMPLE_W-1:0] o_right
);

    always_comb begin
        o_left  = i_left;
        o_right = i_right;
        if (i_empty || i_count == srpm_pkg::COUNT_NONE) begin
            o_left  = '0;
            o_right = '0;
        end else if (i_count == srpm_pkg::COUNT_MONO) begin
            // mono: only mute left applies
            if (i_mode == srpm_pkg::MODE_MUTE_LEFT) begin
                o_left = '0;
            end
            o_right = '0;
        end else begin
            unique case (i_mode)
                srpm_pkg::MODE_MUTE_LEFT:  o_left  = '0;
                srpm_pkg::MODE_MUTE_RIGHT: o_right = '0;
                srpm_pkg::MODE_COPY_L2R:   o_right = i_left;
                srpm_pkg::MODE_COPY_R2L:   o_left  = i_right;
                default: begin
                    o_left  = i_left;
                    o_right = i_right;
                end
            endcase
        end
    end

endmodule

// ===== sv/srpm_lane.sv =====
// one channel lane: magnitude, running block peak and decaying display level
module srpm_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  srpm_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [srpm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [srpm_pkg::LEVEL_W-1:0]         i_upd_peak,
    output logic [srpm_pkg::LEVEL_W-1:0]         o_blk_peak,
    output logic [srpm_pkg::LEVEL_W-1:0]         o_level
);

    logic [srpm_pkg::LEVEL_W-1:0] r_peak;
    logic [srpm_pkg::LEVEL_W-1:0] n_peak;
    logic [srpm_pkg::LEVEL_W-1:0] r_level;
    logic [srpm_pkg::LEVEL_W-1:0] n_level;
    logic [srpm_pkg::LEVEL_W-1:0] w_mag;
    logic [srpm_pkg::LEVEL_W-1:0] w_max;
    logic [srpm_pkg::PROD_W-1:0]  w_prod;

    // full-scale negative maps to 0x8000
    assign w_mag = i_sample[srpm_pkg::SAMPLE_W-1]
                   ? (srpm_pkg::LEVEL_W'(~i_sample) + srpm_pkg::LEVEL_W'(1))
                   : srpm_pkg::LEVEL_W'(i_sample);
    assign w_max = (w_mag > r_peak) ? w_mag : r_peak;
    assign o_blk_peak = i_ctl.track ? w_max : r_peak;

    assign w_prod = srpm_pkg::PROD_W'(r_level) * srpm_pkg::PROD_W'(srpm_pkg::DECAY_MUL);

    always_comb begin
        n_level = r_level;
        if (i_ctl.update) begin
            n_level = (i_upd_peak > r_level)
                      ? i_upd_peak
                      : w_prod[srpm_pkg::PROD_W-1:srpm_pkg::DECAY_SHIFT];
        end
        n_peak = r_peak;
        if (i_ctl.clear) begin
            n_peak = '0;
        end else if (i_ctl.track) begin
            n_peak = w_max;
        end
    end

    assign o_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_level <= '0;
        end else begin
            r_peak  <= n_peak;
            r_level <= n_level;
        end
    end

endmodule

// ===== sv/stereo_route_peak_meter.sv =====
// stereo route peak meter top level: registers, two lanes and the output stage
// output: the result of each input transfer is registered in the output register
// throughput: one frame per cycle unless the output stalls; peak tracking and
//   the level decay multiply settle within the input transfer cycle in each lane
// stall: input ready follows the output register, free or being emptied
// reset: synchronous active low; clears peaks, levels and the output valid,
//   sets channel_mode to stereo and channel_count to two
module stereo_route_peak_meter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srpm_in_if.sink          i_in,
    srpm_out_if.source       o_out,
    srpm_cfg_if.sink         i_cfg
);

    // configuration registers
    logic [srpm_pkg::MODE_W-1:0]  r_mode;
    logic [srpm_pkg::COUNT_W-1:0] r_count;

    // routed samples
    logic signed [srpm_pkg::SAMPLE_W-1:0] w_left;
    logic signed [srpm_pkg::SAMPLE_W-1:0] w_right;

    // lane controls and merge signals
    logic                           w_accept;
    srpm_pkg::t_lane_ctl            w_ctl;
    logic [srpm_pkg::LEVEL_W-1:0]   w_left_blk;
    logic [srpm_pkg::LEVEL_W-1:0]   w_right_blk;
    logic [srpm_pkg::LEVEL_W-1:0]   w_left_upd;
    logic [srpm_pkg::LEVEL_W-1:0]   w_right_upd;
    logic [srpm_pkg::LEVEL_W-1:0]   w_left_level;
    logic [srpm_pkg::LEVEL_W-1:0]   w_right_level;

    // output register
    logic                                 r_out_valid;
    logic signed [srpm_pkg::SAMPLE_W-1:0] r_left_out;
    logic signed [srpm_pkg::SAMPLE_W-1:0] r_right_out;
    logic                                 r_updated;
    logic [srpm_pkg::LEVEL_W-1:0]         r_left_level;
    logic [srpm_pkg::LEVEL_W-1:0]         r_right_level;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= srpm_pkg::MODE_STEREO;
            r_count <= srpm_pkg::COUNT_STEREO;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == srpm_pkg::REG_CHANNEL_MODE) begin
                r_mode <= i_cfg.data[srpm_pkg::MODE_W-1:0];
            end else if (i_cfg.index == srpm_pkg::REG_CHANNEL_COUNT) begin
                r_count <= i_cfg.data[srpm_pkg::COUNT_W-1:0];
            end
        end
    end

    // take a frame whenever the output register is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    srpm_route u_route (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_empty (i_in.block_empty),
        .i_left  (i_in.left_in),
        .i_right (i_in.right_in),
        .o_left  (w_left),
        .o_right (w_right)
    );

    // an empty block only decays and leaves the running peaks alone
    always_comb begin
        w_ctl.track  = w_accept && !i_in.block_empty;
        w_ctl.update = w_accept && (i_in.block_empty || i_in.block_end);
        w_ctl.clear  = w_accept && !i_in.block_empty && i_in.block_end;
    end

    // merge: choose the peak each level sees at the block boundary
    always_comb begin
        w_left_upd  = w_left_blk;
        w_right_upd = w_right_blk;
        if (i_in.block_empty || r_count == srpm_pkg::COUNT_NONE) begin
            w_left_upd  = '0;
            w_right_upd = '0;
        end else if (r_count == srpm_pkg::COUNT_MONO) begin
            // mono: right display follows the left block peak
            w_right_upd = w_left_blk;
        end
    end

    srpm_lane u_lane_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (w_left),
        .i_upd_peak (w_left_upd),
        .o_blk_peak (w_left_blk),
        .o_level    (w_left_level)
    );

    srpm_lane u_lane_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (w_right),
        .i_upd_peak (w_right_upd),
        .o_blk_peak (w_right_blk),
        .o_level    (w_right_level)
    );

    // output register: loads on every input transfer, empties on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left_out    <= w_left;
            r_right_out   <= w_right;
            r_updated     <= w_ctl.update;
            r_left_level  <= w_left_level;
            r_right_level <= w_right_level;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.left_out       = r_left_out;
    assign o_out.right_out      = r_right_out;
    assign o_out.levels_updated = r_updated;
    assign o_out.left_level     = r_left_level;
    assign o_out.right_level    = r_right_level;

endmodule

// ===== sv/srpm_checker.sv =====
// port-level checks for the stereo route peak meter and their bind
module srpm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [srpm_pkg::SAMPLE_W-1:0] i_right_out,
    input logic                                 i_updated,
    input logic [srpm_pkg::LEVEL_W-1:0]         i_left_level,
    input logic [srpm_pkg::LEVEL_W-1:0]         i_right_level,
    input logic                                 i_cfg_valid,
    input logic                                 i_cfg_ready,
    input logic [srpm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [srpm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                         w_out_xfer;
    logic                         r_seen;
    logic [srpm_pkg::LEVEL_W-1:0] r_last_left;
    logic [srpm_pkg::LEVEL_W-1:0] r_last_right;
    logic [srpm_pkg::COUNT_W-1:0] r_count;

    assign w_out_xfer = i_out_valid && i_out_ready;

    // shadow of the channel count and the last delivered levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_count <= srpm_pkg::COUNT_STEREO;
        end else begin
            if (w_out_xfer) begin
                r_seen <= 1'b1;
            end
            if (i_cfg_valid && i_cfg_ready &&
                i_cfg_index == srpm_pkg::REG_CHANNEL_COUNT) begin
                r_count <= i_cfg_data[srpm_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_xfer) begin
            r_last_left  <= i_left_level;
            r_last_right <= i_right_level;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_levels_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && !i_updated && r_seen |->
            i_left_level == r_last_left && i_right_level == r_last_right)
        else $error("levels changed without an update");

    a_levels_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> i_left_level <= srpm_pkg::LEVEL_FULL_SCALE &&
                       i_right_level <= srpm_pkg::LEVEL_FULL_SCALE)
        else $error("level above full scale");

    a_mono_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && (r_count == srpm_pkg::COUNT_MONO || r_count == srpm_pkg::COUNT_NONE)
            |-> i_right_out == '0)
        else $error("right sample nonzero without a right channel");

endmodule

bind stereo_route_peak_meter srpm_checker u_srpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_right_out   (o_out.right_out),
    .i_updated     (o_out.levels_updated),
    .i_left_level  (o_out.left_level),
    .i_right_level (o_out.right_level),
    .i_cfg_valid   (i_cfg.valid),
    .i_cfg_ready   (i_cfg.ready),
    .i_cfg_index   (i_cfg.index),
    .i_cfg_data    (i_cfg.data)
);
